FILE: rtl/blop_pkg.sv
// Shared constants, types and fixed-point helpers for the binomial lattice pricer.
package blop_pkg;

  localparam int MAX_STEPS = 255;
  localparam int PRICE_W   = 32;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int Q_W       = 31;

  // node/price chain is one longer than the lattice width; the power chain is not
  localparam int RING_LEN  = MAX_STEPS + 2;
  localparam int POW_LEN   = MAX_STEPS + 1;
  localparam int CYC_W     = $clog2(RING_LEN);
  localparam int EVAL_LAT  = 3;
  localparam int WR_TAP    = RING_LEN - 1 - EVAL_LAT;

  localparam logic [PRICE_W-1:0] ONE_Q30 = PRICE_W'(64'h4000_0000);
  localparam logic [Q_W-1:0]     ONE_Q  = Q_W'(64'h4000_0000);
  localparam logic [63:0]        HALF_Q30 = 64'h2000_0000;

  localparam logic [2:0] REG_UP   = 3'd0;
  localparam logic [2:0] REG_DOWN = 3'd1;
  localparam logic [2:0] REG_PROB = 3'd2;
  localparam logic [2:0] REG_DISC = 3'd3;
  localparam logic [2:0] REG_STEP = 3'd4;
  localparam logic [2:0] REG_MODE = 3'd5;

  typedef struct packed {
    logic               clip;
    logic [PRICE_W-1:0] val;
  } mulq_t;

  // word heading into the evaluation pipeline
  typedef struct packed {
    logic               valid;
    logic               term;
    logic               root;
    logic [PRICE_W-1:0] v_dn;
    logic [PRICE_W-1:0] v_up;
    logic [PRICE_W-1:0] price;
    logic [PRICE_W-1:0] dpow;
  } blop_feed_t;

  typedef struct packed {
    logic               wr;
    logic               root;
    logic               sat;
    logic [PRICE_W-1:0] value;
  } blop_res_t;

  // a times Q2.30 b, rounded to nearest, clipped at all ones
  function automatic mulq_t mulq(input logic [PRICE_W-1:0] a, input logic [PRICE_W-1:0] b);
    logic [63:0] prod;
    logic [63:0] rnd;
    mulq_t       res;
    prod = {32'b0, a} * {32'b0, b};
    rnd  = (prod + HALF_Q30) >> 30;
    res.clip = |rnd[63:PRICE_W];
    res.val  = res.clip ? '1 : rnd[PRICE_W-1:0];
    return res;
  endfunction

endpackage

FILE: rtl/blop_if.sv
// Valid/ready channel interfaces for the pricer's input and result words.
interface blop_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] spot_price;
  logic [31:0] strike_price;
  modport source (output valid, output spot_price, output strike_price, input ready);
  modport sink   (input valid, input spot_price, input strike_price, output ready);
endinterface

interface blop_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] option_value;
  logic        saturated;
  modport source (output valid, output option_value, output saturated, input ready);
  modport sink   (input valid, input option_value, input saturated, output ready);
endinterface

FILE: rtl/blop_node_cell.sv
// One cell of the rotating node-value / node-price chain.
module blop_node_cell (
  input  logic                        clk,
  input  logic                        shift,
  input  logic                        wr_en,
  input  logic [blop_pkg::PRICE_W-1:0] wr_val,
  input  logic [blop_pkg::PRICE_W-1:0] v_in,
  input  logic [blop_pkg::PRICE_W-1:0] p_in,
  output logic [blop_pkg::PRICE_W-1:0] v_out,
  output logic [blop_pkg::PRICE_W-1:0] p_out
);
  import blop_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      // a finished node overrides the value passing through this cell
      v_out <= wr_en ? wr_val : v_in;
      p_out <= p_in;
    end
  end

endmodule

FILE: rtl/blop_pow_cell.sv
// One cell of the power-of-d chain: pushes up while loading, rotates down while pricing.
module blop_pow_cell (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        rot,
  input  logic [blop_pkg::PRICE_W-1:0] from_lo,
  input  logic [blop_pkg::PRICE_W-1:0] from_hi,
  output logic [blop_pkg::PRICE_W-1:0] d
);
  import blop_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      d <= from_lo;
    end else if (rot) begin
      d <= from_hi;
    end
  end

endmodule

FILE: rtl/blop_eval.sv
// Node evaluation pipeline: mix, discount, payoff and early exercise.
module blop_eval (
  input  logic                        clk,
  input  logic                        rst,
  input  blop_pkg::blop_feed_t        feed,
  input  logic [blop_pkg::Q_W-1:0]     up_prob,
  input  logic [blop_pkg::Q_W-1:0]     disc_factor,
  input  logic [blop_pkg::PRICE_W-1:0] strike,
  input  logic                        put,
  input  logic                        amer,
  output blop_pkg::blop_res_t         res
);
  import blop_pkg::*;

  logic [PRICE_W-1:0] q32, qn32, disc32;
  mulq_t mu, md, ms, mv;

  logic v1, t1, r1, sat1;
  logic [PRICE_W-1:0] m_up1, m_dn1, price1;
  logic v2, t2, r2, sat2;
  logic [PRICE_W-1:0] mix2, ex2;
  logic v3, t3, r3, sat3;
  logic [PRICE_W-1:0] vd3, ex3;

  logic [PRICE_W:0]   sum;
  logic [PRICE_W-1:0] mix, ex;

  // probability and discount above 1.0 act as 1.0
  assign q32    = {1'b0, (up_prob > ONE_Q) ? ONE_Q : up_prob};
  assign qn32   = ONE_Q30 - q32;
  assign disc32 = {1'b0, (disc_factor > ONE_Q) ? ONE_Q : disc_factor};

  assign mu = mulq(feed.v_up, q32);
  assign md = mulq(feed.v_dn, qn32);
  assign ms = mulq(feed.price, feed.dpow);

  assign sum = {1'b0, m_up1} + {1'b0, m_dn1};
  assign mix = sum[PRICE_W] ? '1 : sum[PRICE_W-1:0];
  always_comb begin
    if (put) begin
      ex = (strike > price1) ? strike - price1 : '0;
    end else begin
      ex = (price1 > strike) ? price1 - strike : '0;
    end
  end

  assign mv = mulq(mix2, disc32);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= feed.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    t1     <= feed.term;
    r1     <= feed.root;
    m_up1  <= mu.val;
    m_dn1  <= md.val;
    price1 <= ms.val;
    // the price product counts only where it is used
    sat1   <= (!feed.term && (mu.clip || md.clip)) || ((feed.term || amer) && ms.clip);

    t2   <= t1;
    r2   <= r1;
    mix2 <= mix;
    ex2  <= ex;
    sat2 <= sat1 || (!t1 && sum[PRICE_W]);

    t3   <= t2;
    r3   <= r2;
    vd3  <= mv.val;
    ex3  <= ex2;
    sat3 <= sat2 || (!t2 && mv.clip);
  end

  always_comb begin
    res.wr   = v3;
    res.root = v3 && r3;
    res.sat  = v3 && sat3;
    if (t3) begin
      res.value = ex3;
    end else if (amer && (ex3 > vd3)) begin
      res.value = ex3;
    end else begin
      res.value = vd3;
    end
  end

endmodule

FILE: rtl/binomial_lattice_option_pricer_unit.sv
// Binomial lattice option pricer: one option per input word, root value out.
// For each input word, a load sweep of one rotation builds the price and
// power chains, then every lattice level, the terminal one included, is one
// full rotation of the 257-cell node chain past a single three-stage
// evaluation pipeline; the root level stops once the root leaves it.
// A new word is taken once the previous root has
// been handed to the result register, which may still be waiting downstream.
module binomial_lattice_option_pricer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  blop_in_if.sink     item,
  blop_out_if.source  result
);
  import blop_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_PASS = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;
  localparam logic [CYC_W-1:0] LAST_CYC = CYC_W'(RING_LEN - 1);

  logic [PRICE_W-1:0] up_factor, down_factor;
  logic [Q_W-1:0]     up_prob, disc_factor;
  logic [STEP_W-1:0]  step_count;
  logic [1:0]         payoff_mode;

  logic [1:0]         state;
  logic [CYC_W-1:0]   cyc;
  logic [STEP_W-1:0]  level, n_steps;
  logic               term, sat_acc;
  logic [PRICE_W-1:0] strike, cur_p, cur_d, root_val;
  logic               root_sat;
  logic               res_valid, res_sat;
  logic [PRICE_W-1:0] res_value;

  logic [PRICE_W-1:0] v_q [RING_LEN];
  logic [PRICE_W-1:0] p_q [RING_LEN];
  logic [PRICE_W-1:0] d_q [POW_LEN];
  logic [PRICE_W-1:0] p_tail;
  logic               ring_shift, d_load, d_rot, pushing;

  mulq_t      mp, md;
  blop_feed_t feed;
  blop_res_t  ev;

  assign item.ready          = (state == S_IDLE);
  assign result.valid        = res_valid;
  assign result.option_value = res_value;
  assign result.saturated    = res_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_factor   <= ONE_Q30;
      down_factor <= ONE_Q30;
      up_prob     <= ONE_Q >> 1;
      disc_factor <= ONE_Q;
      step_count  <= STEP_W'(1);
      payoff_mode <= 2'd0;
    end else if (wr_en) begin
      case (wr_index)
        REG_UP:   up_factor   <= wr_data;
        REG_DOWN: down_factor <= wr_data;
        REG_PROB: up_prob     <= wr_data[Q_W-1:0];
        REG_DISC: disc_factor <= wr_data[Q_W-1:0];
        REG_STEP: step_count  <= wr_data[STEP_W-1:0];
        REG_MODE: payoff_mode <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  assign pushing    = (state == S_LOAD) && (cyc <= CYC_W'(n_steps));
  assign ring_shift = (state == S_LOAD) || (state == S_PASS);
  assign d_load     = pushing;
  assign d_rot      = (state == S_PASS);
  assign p_tail     = pushing ? cur_p : p_q[0];

  assign mp = mulq(cur_p, up_factor);
  assign md = mulq(cur_d, down_factor);

  for (genvar k = 0; k < RING_LEN; k++) begin : g_node
    logic [PRICE_W-1:0] v_in, p_in;
    if (k == RING_LEN - 1) begin : g_tail
      assign v_in = v_q[0];
      assign p_in = p_tail;
    end else begin : g_mid
      assign v_in = v_q[k+1];
      assign p_in = p_q[k+1];
    end
    blop_node_cell u_cell (
      .clk    (clk),
      .shift  (ring_shift),
      .wr_en  ((k == WR_TAP) && ev.wr),
      .wr_val (ev.value),
      .v_in   (v_in),
      .p_in   (p_in),
      .v_out  (v_q[k]),
      .p_out  (p_q[k])
    );
  end

  for (genvar k = 0; k < POW_LEN; k++) begin : g_pow
    logic [PRICE_W-1:0] lo, hi;
    if (k == 0) begin : g_lo
      assign lo = cur_d;
    end else begin : g_lo_mid
      assign lo = d_q[k-1];
    end
    if (k == POW_LEN - 1) begin : g_hi
      assign hi = d_q[0];
    end else begin : g_hi_mid
      assign hi = d_q[k+1];
    end
    blop_pow_cell u_cell (
      .clk     (clk),
      .load    (d_load),
      .rot     (d_rot),
      .from_lo (lo),
      .from_hi (hi),
      .d       (d_q[k])
    );
  end

  always_comb begin
    feed.valid = (state == S_PASS) && (cyc <= CYC_W'(level));
    feed.term  = term;
    feed.root  = (level == '0) && (cyc == '0);
    feed.v_dn  = v_q[0];
    feed.v_up  = v_q[1];
    feed.price = p_q[0];
    feed.dpow  = d_q[0];
  end

  blop_eval u_eval (
    .clk         (clk),
    .rst         (rst),
    .feed        (feed),
    .up_prob     (up_prob),
    .disc_factor (disc_factor),
    .strike      (strike),
    .put         (payoff_mode[0]),
    .amer        (payoff_mode[1]),
    .res         (ev)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            strike  <= item.strike_price;
            cur_p   <= item.spot_price;
            cur_d   <= ONE_Q30;
            cyc     <= '0;
            n_steps <= step_count;
            sat_acc <= 1'b0;
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          cur_p <= mp.val;
          cur_d <= md.val;
          if (cyc < CYC_W'(n_steps) && (mp.clip || md.clip)) begin
            sat_acc <= 1'b1;
          end
          if (cyc == LAST_CYC) begin
            cyc   <= '0;
            level <= n_steps;
            term  <= 1'b1;
            state <= S_PASS;
          end else begin
            cyc <= cyc + 1'b1;
          end
        end
        S_PASS: begin
          if (ev.sat) begin
            sat_acc <= 1'b1;
          end
          if (ev.root) begin
            root_val <= ev.value;
            root_sat <= sat_acc || ev.sat;
            state    <= S_DONE;
          end else if (cyc == LAST_CYC) begin
            // one rotation done: step back one level
            cyc   <= '0;
            term  <= 1'b0;
            level <= level - 1'b1;
          end else begin
            cyc <= cyc + 1'b1;
          end
        end
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_valid <= 1'b1;
            res_value <= root_val;
            res_sat   <= root_sat;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/blop_checker.sv
// Port-level checks on the pricer's channels, bound to the top level.
module blop_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] option_value
);

  // one word in flight: input closes once a word is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after a word was taken");

  // no result can appear right after a word is taken
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised just after a word was taken");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(option_value))
    else $error("stalled result dropped or changed");

endmodule

bind binomial_lattice_option_pricer_unit blop_checker u_blop_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item.valid),
  .in_ready     (item.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .option_value (result.option_value)
);

FILE: tb/tb_binomial_lattice_option_pricer_unit.sv
// Self-checking testbench for the binomial lattice option pricer.
`timescale 1ns / 1ps

module tb_binomial_lattice_option_pricer_unit;
  import blop_pkg::*;

  localparam logic [1:0] MODE_CALL     = 2'b00;
  localparam logic [1:0] MODE_PUT      = 2'b01;
  localparam logic [1:0] MODE_AMERICAN = 2'b10;
  localparam logic [63:0] Q30_ONE      = 64'h4000_0000;
  localparam logic [63:0] VALUE_MAX    = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } priced_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [31:0] wr_data;

  blop_in_if  in_if ();
  blop_out_if out_if ();

  binomial_lattice_option_pricer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (in_if),
    .result   (out_if)
  );

  // shadow copy of the configuration
  logic [31:0] cfg_up;
  logic [31:0] cfg_down;
  logic [30:0] cfg_prob;
  logic [30:0] cfg_disc;
  logic [7:0]  cfg_steps;
  logic [1:0]  cfg_mode;

  priced_t expected_prices[$];
  int      mismatches;
  bit      idle_on;
  int      hold_left;
  int      stall_left;
  bit      sat_acc;

  always #5 clk = ~clk;

  function automatic logic [63:0] scale_q30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = (a * b + 64'h2000_0000) >> 30;
    if (r > VALUE_MAX) begin
      sat_acc = 1'b1;
      r = VALUE_MAX;
    end
    return r;
  endfunction

  function automatic logic [63:0] payoff_of(input logic [63:0] s, input logic [63:0] k,
                                             input bit put);
    if (put) return (k > s) ? k - s : 64'd0;
    return (s > k) ? s - k : 64'd0;
  endfunction

  function automatic priced_t price_option(input logic [31:0] spot, input logic [31:0] strike);
    logic [63:0] vals [0:255];
    logic [63:0] prices [0:255];
    logic [63:0] dp [0:255];
    logic [63:0] q;
    logic [63:0] disc;
    logic [63:0] mix;
    logic [63:0] v;
    logic [63:0] s;
    logic [63:0] ex;
    bit          put;
    bit          amer;
    int          n;
    priced_t     r;
    sat_acc = 1'b0;
    put  = (cfg_mode & MODE_PUT) != 0;
    amer = (cfg_mode & MODE_AMERICAN) != 0;
    q    = ({33'd0, cfg_prob} > Q30_ONE) ? Q30_ONE : {33'd0, cfg_prob};
    disc = ({33'd0, cfg_disc} > Q30_ONE) ? Q30_ONE : {33'd0, cfg_disc};
    n    = cfg_steps;
    dp[0] = Q30_ONE;
    prices[0] = {32'd0, spot};
    for (int j = 1; j <= n; j++) begin
      dp[j] = scale_q30(dp[j-1], {32'd0, cfg_down});
      prices[j] = scale_q30(prices[j-1], {32'd0, cfg_up});
    end
    for (int j = 0; j <= n; j++) begin
      s = scale_q30(prices[j], dp[n-j]);
      vals[j] = payoff_of(s, {32'd0, strike}, put);
    end
    for (int i = n - 1; i >= 0; i--) begin
      for (int j = 0; j <= i; j++) begin
        mix = scale_q30(vals[j+1], q) + scale_q30(vals[j], Q30_ONE - q);
        if (mix > VALUE_MAX) begin
          mix = VALUE_MAX;
          sat_acc = 1'b1;
        end
        v = scale_q30(mix, disc);
        if (amer) begin
          s = scale_q30(prices[j], dp[i-j]);
          ex = payoff_of(s, {32'd0, strike}, put);
          if (ex > v) v = ex;
        end
        vals[j] = v;
      end
    end
    r.value = vals[0][31:0];
    r.sat   = sat_acc;
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    case (idx)
      REG_UP:   cfg_up    = data;
      REG_DOWN: cfg_down  = data;
      REG_PROB: cfg_prob  = data[30:0];
      REG_DISC: cfg_disc  = data[30:0];
      REG_STEP: cfg_steps = data[7:0];
      REG_MODE: cfg_mode  = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] u, input logic [31:0] d, input logic [31:0] q,
                            input logic [31:0] disc, input logic [7:0] n, input logic [1:0] m);
    write_reg(REG_UP, u);
    write_reg(REG_DOWN, d);
    write_reg(REG_PROB, q);
    write_reg(REG_DISC, disc);
    write_reg(REG_STEP, {24'd0, n});
    write_reg(REG_MODE, {30'd0, m});
  endtask

  // offer one word, optionally after a random gap, and predict it once taken
  task automatic send_word(input logic [31:0] spot, input logic [31:0] strike);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid        <= 1'b1;
    in_if.spot_price   <= spot;
    in_if.strike_price <= strike;
    forever begin
      @(posedge clk);
      if (in_if.ready) break;
    end
    expected_prices.push_back(price_option(spot, strike));
  endtask

  // stop offering and hold until every result is back
  task automatic drain;
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_prices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_result;
    priced_t want;
    if (expected_prices.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: value %h sat %b",
                 out_if.option_value, out_if.saturated);
    end else begin
      want = expected_prices.pop_front();
      if (out_if.option_value !== want.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("option_value mismatch: expected %h actual %h",
                   want.value, out_if.option_value);
      end
      if (out_if.saturated !== want.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("saturated mismatch: expected %b actual %b",
                   want.sat, out_if.saturated);
      end
    end
  endtask

  // result side: check, then decide ready for the next edge
  initial begin
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) check_result();
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_reset_values;
    cfg_up = ONE_Q30; cfg_down = ONE_Q30; cfg_prob = ONE_Q; cfg_prob = cfg_prob >> 1;
    cfg_disc = ONE_Q; cfg_steps = 8'd1; cfg_mode = MODE_CALL;
    send_word(32'h0000_0000, 32'h0000_0000);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'h0064_0000, 32'h005A_0000);
    drain();
  endtask

  task automatic test_payoff_modes;
    for (int m = 0; m < 4; m++) begin
      set_config(32'd1181116006, 32'd976128931, 32'd590558003, 32'd1072668082, 8'd4, m[1:0]);
      send_word(32'h0064_0000, 32'h005A_0000);
      send_word(32'h0050_0000, 32'h0064_8000);
      drain();
    end
  endtask

  task automatic test_step_extremes;
    set_config(32'd1181116006, 32'd976128931, 32'd590558003, 32'd1072668082, 8'd0, MODE_PUT);
    send_word(32'h0050_0000, 32'h0064_0000);
    drain();
    set_config(32'd1084479488, 32'd1063105088, 32'd536870912, 32'd1073000000, 8'd255,
               MODE_PUT | MODE_AMERICAN);
    send_word(32'h0064_0000, 32'h0064_0000);
    drain();
    write_reg(REG_MODE, {30'd0, MODE_CALL});
    send_word(32'h0064_0000, 32'h0060_0000);
    drain();
  endtask

  task automatic test_saturation;
    // factors at the top of their range clip prices and powers
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd3, MODE_CALL);
    send_word(32'hF000_0000, 32'h0000_0000);
    send_word(32'h0001_0000, 32'h0000_8000);
    drain();
    set_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'd2,
               MODE_PUT | MODE_AMERICAN);
    send_word(32'h1234_5678, 32'h8765_4321);
    drain();
    // equal halves of two all-ones values overflow the mix
    set_config(ONE_Q30, ONE_Q30, 32'h2000_0000, ONE_Q30, 8'd2, MODE_CALL);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    drain();
  endtask

  task automatic test_backpressure;
    set_config(32'd1181116006, 32'd976128931, 32'd590558003, 32'd1072668082, 8'd1,
               MODE_AMERICAN);
    hold_left = 4000;
    for (int i = 0; i < 6; i++) send_word($urandom, $urandom);
    drain();
  endtask

  task automatic random_config;
    logic [31:0] u;
    logic [31:0] d;
    logic [31:0] q;
    logic [31:0] disc;
    logic [7:0]  n;
    u    = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(32'h4000_0000, 32'h5000_0000);
    d    = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(32'h3000_0000, 32'h4000_0000);
    q    = ($urandom_range(0, 7) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                       : $urandom_range(0, 32'h4000_0000);
    disc = ($urandom_range(0, 7) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                       : $urandom_range(32'h3F00_0000, 32'h4000_0000);
    n    = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(7, 40))
                                        : 8'($urandom_range(0, 6));
    set_config(u, d, q, disc, n, 2'($urandom_range(0, 3)));
  endtask

  task automatic test_random;
    logic [31:0] spot;
    logic [31:0] strike;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase >= 8) idle_on = 1'b0;
      random_config();
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          spot = $urandom;
          strike = $urandom;
        end else begin
          spot = $urandom_range(32'h0001_0000, 32'h00C8_0000);
          strike = spot + $urandom_range(0, 32'h0014_0000) - 32'h000A_0000;
        end
        send_word(spot, strike);
      end
      drain();
    end
  endtask

  initial begin
    #30_000_000;
    $display("[binomial_lattice_option_pricer_unit] ERROR");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = 3'd0;
    wr_data = 32'd0;
    in_if.valid = 1'b0;
    in_if.spot_price = 32'd0;
    in_if.strike_price = 32'd0;
    out_if.ready = 1'b0;
    mismatches = 0;
    hold_left = 0;
    stall_left = 0;
    idle_on = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_payoff_modes();
    test_step_extremes();
    test_saturation();
    test_backpressure();
    test_random();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_prices.size() == 0) begin
      $display("[binomial_lattice_option_pricer_unit] OK");
    end else begin
      $display("[binomial_lattice_option_pricer_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/blop_pkg.sv
rtl/blop_if.sv
rtl/blop_node_cell.sv
rtl/blop_pow_cell.sv
rtl/blop_eval.sv
rtl/binomial_lattice_option_pricer_unit.sv
rtl/blop_checker.sv
tb/tb_binomial_lattice_option_pricer_unit.sv
